>>> sv/pal_pkg.sv
// Package for the positional array list: sizes, request and status codes,
// and the command record passed from the front end to the back end. No dependencies.
`default_nettype none

package pal_pkg;

	localparam int DEPTH  = 16;
	localparam int REC_W  = 32;
	localparam int DATA_W = 32;
	localparam int POS_W  = 5;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

	// Command queue between the front end and the back end (a power of two).
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		KIND_READ      = 2'd0,
		KIND_OVERWRITE = 2'd1,
		KIND_INSERT    = 2'd2,
		KIND_DELETE    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_BADPOS = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_READ,
		OP_WRITE,
		OP_INSERT,
		OP_DELETE
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] idx;
		logic [REC_W-1:0] value;
		logic [CNT_W-1:0] length;
		status_t          status;
	} cmd_t;

	typedef struct packed {
		logic push;
		logic full;
	} q_wr_t;

endpackage

`default_nettype wire

>>> sv/pal_ifs.sv
// Request and response channel interfaces of the positional array list.
// Depends on pal_pkg for the field widths.
`default_nettype none

interface pal_in_if import pal_pkg::*;;
	logic             valid;
	logic             ready;
	logic [1:0]       kind;
	logic [POS_W-1:0] position;
	logic [31:0]      value;

	modport source (output valid, output kind, output position, output value, input ready);
	modport sink (input valid, input kind, input position, input value, output ready);
endinterface

interface pal_out_if import pal_pkg::*;;
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_data;
	logic [CNT_W-1:0]  list_length;
	logic [1:0]        status;

	modport source (output valid, output read_data, output list_length, output status,
		input ready);
	modport sink (input valid, input read_data, input list_length, input status,
		output ready);
endinterface

`default_nettype wire

>>> sv/pal_front.sv
// Front end: accepts requests, checks them against the tracked length and
// issues classified commands. Depends on pal_pkg and pal_ifs.
`default_nettype none

module pal_front import pal_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	pal_in_if.sink     req,
	input  wire logic  q_full,
	output q_wr_t      q_wr,
	output cmd_t       q_cmd
);

	logic [CNT_W-1:0] count_q;
	logic [CMP_W-1:0] pos_c;
	logic [CMP_W-1:0] cnt_c;
	logic             accept;
	cmd_t             cmd;

	assign req.ready = !q_full;
	assign accept    = req.valid && req.ready;
	assign pos_c     = CMP_W'(req.position);
	assign cnt_c     = CMP_W'(count_q);

	// The length is known here the moment a request is classified, so the
	// next request can be checked without waiting for the back end.
	always_comb begin
		cmd.op     = OP_NOP;
		cmd.idx    = req.position[IDX_W-1:0];
		cmd.value  = req.value[REC_W-1:0];
		cmd.length = count_q;
		cmd.status = ST_OK;
		unique case (kind_t'(req.kind))
			KIND_READ: begin
				if (pos_c < cnt_c) cmd.op = OP_READ;
				else cmd.status = ST_BADPOS;
			end
			KIND_OVERWRITE: begin
				if (pos_c < cnt_c) cmd.op = OP_WRITE;
				else cmd.status = ST_BADPOS;
			end
			KIND_INSERT: begin
				if (count_q == CNT_W'(DEPTH)) begin
					cmd.status = ST_FULL;
				end else if (pos_c > cnt_c) begin
					cmd.status = ST_BADPOS;
				end else begin
					cmd.op     = OP_INSERT;
					cmd.length = count_q + CNT_W'(1);
				end
			end
			KIND_DELETE: begin
				if (pos_c >= cnt_c) begin
					cmd.status = ST_BADPOS;
				end else begin
					cmd.op     = OP_DELETE;
					cmd.length = count_q - CNT_W'(1);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= cmd.length;
		end
	end

	assign q_wr.push = accept;
	assign q_wr.full = q_full;
	assign q_cmd     = cmd;

endmodule

`default_nettype wire

>>> sv/pal_queue.sv
// Short command queue that decouples the front end from the back end.
// Depends on pal_pkg.
`default_nettype none

module pal_queue import pal_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire q_wr_t wr,
	input  wire cmd_t  wr_cmd,
	output logic       full,
	output logic       rd_valid,
	output cmd_t       rd_cmd,
	input  wire logic  pop
);

	cmd_t              slots_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;
	logic              do_push;
	logic              do_pop;

	assign full     = fill_q == QCNT_W'(QDEPTH);
	assign rd_valid = fill_q != '0;
	assign rd_cmd   = slots_q[rd_ptr_q];
	assign do_push  = wr.push && !full;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_push) slots_q[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (do_push && !do_pop) fill_q <= fill_q + QCNT_W'(1);
			else if (do_pop && !do_push) fill_q <= fill_q - QCNT_W'(1);
		end
	end

endmodule

`default_nettype wire

>>> sv/pal_back.sv
// Back end: holds the entries in registers, carries out one command per cycle while the
// response register is free or being taken (with the whole-list shift for insert and
// delete) and registers the response. Depends on pal_pkg and pal_ifs.
`default_nettype none

module pal_back import pal_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	input  wire cmd_t cmd,
	output logic      pop,
	pal_out_if.source rsp
);

	logic [REC_W-1:0]  entries_q [DEPTH];
	logic              out_valid_q;
	logic [DATA_W-1:0] data_q;
	logic [CNT_W-1:0]  length_q;
	status_t           status_q;

	// The response register frees up in the same cycle its transfer completes.
	assign pop = cmd_valid && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk) begin
		if (pop) begin
			unique case (cmd.op)
				OP_WRITE: entries_q[cmd.idx] <= cmd.value;
				OP_INSERT: begin
					for (int i = 1; i < DEPTH; i++) begin
						if (IDX_W'(i) > cmd.idx) entries_q[i] <= entries_q[i-1];
					end
					entries_q[cmd.idx] <= cmd.value;
				end
				OP_DELETE: begin
					for (int i = 0; i < DEPTH - 1; i++) begin
						if (IDX_W'(i) >= cmd.idx) entries_q[i] <= entries_q[i+1];
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q   <= (cmd.op == OP_READ) ? DATA_W'(entries_q[cmd.idx]) : '0;
			length_q <= cmd.length;
			status_q <= cmd.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.read_data   = data_q;
	assign rsp.list_length = length_q;
	assign rsp.status      = status_q;

endmodule

`default_nettype wire

>>> sv/positional_array_list_core.sv
// Positional array list: an ordered list of up to 16 words of 32 bits. Each request reads,
// overwrites, inserts or deletes at a position, and returns one response with the read data
// (zero unless a good read), the length after the request and a status (ok, full, invalid
// position). Throughput is one request per cycle while the queue has room and responses are
// taken; each request is written into the command queue, then the back end takes it and
// registers its response, which holds until taken. The front end tracks the length and
// classifies each request at once, a two-entry command queue sits between it and the back
// end, and the back end keeps every entry in a register so an insert or delete shifts the
// whole list at once. Entries hold no reset value; there is no clearing pass after reset.
`default_nettype none

module positional_array_list_core import pal_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	pal_in_if.sink    req,
	pal_out_if.source rsp
);

	q_wr_t q_wr;
	cmd_t  front_cmd;
	cmd_t  back_cmd;
	logic  q_full;
	logic  q_valid;
	logic  q_pop;

	pal_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.q_full (q_full),
		.q_wr   (q_wr),
		.q_cmd  (front_cmd)
	);

	pal_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_wr),
		.wr_cmd   (front_cmd),
		.full     (q_full),
		.rd_valid (q_valid),
		.rd_cmd   (back_cmd),
		.pop      (q_pop)
	);

	pal_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (back_cmd),
		.pop       (q_pop),
		.rsp       (rsp)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr.push |-> !q_wr.full)
		else $error("command queue written while full");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.list_length <= CNT_W'(DEPTH))
		else $error("list length beyond depth");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == ST_FULL) |-> rsp.list_length == CNT_W'(DEPTH))
		else $error("full status with a list that is not full");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != ST_OK) |-> rsp.read_data == '0)
		else $error("failed request returned data");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> rsp.valid)
		else $error("command taken without a response");

endmodule

`default_nettype wire
